// ===== rtl/fce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_pkg
// Shared constants, codes and types of the chain engine.
// ----------------------------------------------------------------------------
package fce_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int ADDR_W     = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = ADDR_W;
	localparam int NB_W       = ADDR_W + 1;
	localparam int FB_W       = 9;
	localparam int FB_MAX     = 256;
	localparam int NB_MIN     = 4;

	// link entry codes
	localparam logic [LINK_W-1:0] LINK_FREE = LINK_W'(0);
	localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(1);
	localparam logic [LINK_W-1:0] LINK_BUSY = LINK_W'(2);

	// request kinds
	localparam logic [1:0] KIND_FORMAT = 2'd0;
	localparam logic [1:0] KIND_WALK   = 2'd1;
	localparam logic [1:0] KIND_FREE   = 2'd2;

	// result status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_FREE  = 2'd1;
	localparam logic [1:0] STAT_PAST_END = 2'd2;
	localparam logic [1:0] STAT_BROKEN   = 2'd3;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FAT_BLOCKS = 1'b1;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block;
		logic [ADDR_W-1:0] first_block;
		logic [NB_W-1:0]   new_blocks;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b0000000001,
		ST_IDLE    = 10'b0000000010,
		ST_HOP     = 10'b0000000100,
		ST_HOP_EV  = 10'b0000001000,
		ST_SRCH    = 10'b0000010000,
		ST_SRCH_EV = 10'b0000100000,
		ST_LINK    = 10'b0001000000,
		ST_FREE_RD = 10'b0010000000,
		ST_FREE_EV = 10'b0100000000,
		ST_DONE    = 10'b1000000000
	} seq_state_t;

	function automatic logic [NB_W-1:0] sat_blocks(input logic [NB_W-1:0] v);
		logic [NB_W-1:0] r;
		if (v < NB_W'(NB_MIN))
			r = NB_W'(NB_MIN);
		else if (v > NB_W'(MAX_BLOCKS))
			r = NB_W'(MAX_BLOCKS);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [FB_W-1:0] sat_fat(input logic [FB_W-1:0] v);
		logic [FB_W-1:0] r;
		if (v == '0)
			r = FB_W'(1);
		else if (v > FB_W'(FB_MAX))
			r = FB_W'(FB_MAX);
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== rtl/fce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fce_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_out
// Result register that holds one finished result until it is taken.
// ----------------------------------------------------------------------------
module fce_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  fce_pkg::res_t res,
	output logic          can_load,
	output logic          out_valid,
	input  logic          out_ready,
	output fce_pkg::res_t data
);

	logic          valid_q;
	fce_pkg::res_t data_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign data      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= res;
	end

endmodule

// ===== rtl/fce_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_seq
// Request sequencer: table sweeps, chain walks, free-block search and chain
// release, all as read and write steps on the link table memory.
// ----------------------------------------------------------------------------
module fce_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fce_pkg::NB_W-1:0]      n_q,
	input  logic [fce_pkg::FB_W-1:0]      fb_q,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic                          has_start,
	input  logic [fce_pkg::ADDR_W-1:0]    start_block,
	input  logic [fce_pkg::ADDR_W-1:0]    hop_count,
	input  logic                          extend,
	output fce_pkg::mem_req_t             mem_req,
	input  logic [fce_pkg::LINK_W-1:0]    mem_rdata,
	output logic                          res_load,
	output fce_pkg::res_t                 res,
	input  logic                          res_can_load
);

	fce_pkg::seq_state_t state_q;

	logic [fce_pkg::ADDR_W-1:0] clr_q;
	logic                       fmt_q;
	logic [fce_pkg::NB_W-1:0]   lo_q;

	logic [fce_pkg::ADDR_W-1:0] b_q;
	logic [fce_pkg::ADDR_W-1:0] first_q;
	logic [fce_pkg::NB_W-1:0]   cnt_q;
	logic [fce_pkg::ADDR_W-1:0] hops_q;
	logic [fce_pkg::NB_W-1:0]   s_q;
	logic [fce_pkg::NB_W-1:0]   i_q;
	logic [1:0]                 st_q;
	logic                       ext_q;
	logic                       pend_first_q;

	logic acc;
	logic empty_in;
	logic has_chain;
	logic nx_end;
	logic nx_bad;
	logic s_out;
	logic s_free;
	logic hops_zero;
	logic clr_last;
	logic i_last;
	logic fmt_busy;

	assign in_ready  = (state_q == fce_pkg::ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign empty_in  = !has_start || ({1'b0, start_block} >= n_q);
	assign has_chain = ((kind == fce_pkg::KIND_WALK) || (kind == fce_pkg::KIND_FREE)) && !empty_in;
	assign nx_end    = (mem_rdata == fce_pkg::LINK_END);
	assign nx_bad    = ({1'b0, mem_rdata} >= n_q);
	assign s_out     = (s_q >= n_q);
	assign s_free    = (mem_rdata == fce_pkg::LINK_FREE);
	assign hops_zero = (hops_q == '0);
	assign clr_last  = (clr_q == '1);
	assign i_last    = (i_q == n_q);
	// blocks 0, 1 and the table blocks that fit on the disk
	assign fmt_busy  = ({1'b0, clr_q} < fce_pkg::NB_W'(2)) ||
		(({1'b0, clr_q} < ({2'b0, fb_q} + fce_pkg::NB_W'(2))) && ({1'b0, clr_q} < n_q));

	assign res_load = (state_q == fce_pkg::ST_DONE) && res_can_load;
	assign res      = '{status: st_q, block: b_q, first_block: first_q, new_blocks: cnt_q};

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			fce_pkg::ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = (fmt_q && fmt_busy) ? fce_pkg::LINK_BUSY : fce_pkg::LINK_FREE;
			end
			fce_pkg::ST_HOP: begin
				mem_req.re    = !hops_zero;
				mem_req.raddr = b_q;
			end
			fce_pkg::ST_SRCH: begin
				mem_req.re    = !s_out;
				mem_req.raddr = s_q[fce_pkg::ADDR_W-1:0];
			end
			fce_pkg::ST_SRCH_EV: begin
				mem_req.we    = s_free;
				mem_req.waddr = s_q[fce_pkg::ADDR_W-1:0];
				mem_req.wdata = fce_pkg::LINK_END;
			end
			fce_pkg::ST_LINK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = b_q;
				mem_req.wdata = s_q[fce_pkg::ADDR_W-1:0];
			end
			fce_pkg::ST_FREE_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = b_q;
			end
			fce_pkg::ST_FREE_EV: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = b_q;
				mem_req.wdata = fce_pkg::LINK_FREE;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// control state; lo_q is a low-water mark: every entry below it is in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fce_pkg::ST_CLEAR;
			clr_q   <= '0;
			fmt_q   <= 1'b0;
			lo_q    <= '0;
		end else begin
			unique case (state_q)
				fce_pkg::ST_CLEAR: begin
					clr_q <= clr_q + fce_pkg::ADDR_W'(1);
					if (clr_last) begin
						lo_q    <= '0;
						state_q <= fmt_q ? fce_pkg::ST_DONE : fce_pkg::ST_IDLE;
					end
				end
				fce_pkg::ST_IDLE: begin
					if (acc) begin
						priority if (kind == fce_pkg::KIND_FORMAT) begin
							fmt_q   <= 1'b1;
							clr_q   <= '0;
							state_q <= fce_pkg::ST_CLEAR;
						end else if (kind == fce_pkg::KIND_WALK) begin
							if (!empty_in)
								state_q <= fce_pkg::ST_HOP;
							else
								state_q <= extend ? fce_pkg::ST_SRCH : fce_pkg::ST_DONE;
						end else if (kind == fce_pkg::KIND_FREE) begin
							state_q <= empty_in ? fce_pkg::ST_DONE : fce_pkg::ST_FREE_RD;
						end else begin
							state_q <= fce_pkg::ST_DONE;
						end
					end
				end
				fce_pkg::ST_HOP: begin
					state_q <= hops_zero ? fce_pkg::ST_DONE : fce_pkg::ST_HOP_EV;
				end
				fce_pkg::ST_HOP_EV: begin
					if (nx_end)
						state_q <= ext_q ? fce_pkg::ST_SRCH : fce_pkg::ST_DONE;
					else if (nx_bad)
						state_q <= fce_pkg::ST_DONE;
					else
						state_q <= fce_pkg::ST_HOP;
				end
				fce_pkg::ST_SRCH: begin
					state_q <= s_out ? fce_pkg::ST_DONE : fce_pkg::ST_SRCH_EV;
				end
				fce_pkg::ST_SRCH_EV: begin
					if (s_free) begin
						lo_q    <= s_q + fce_pkg::NB_W'(1);
						state_q <= pend_first_q ? fce_pkg::ST_HOP : fce_pkg::ST_LINK;
					end else begin
						state_q <= fce_pkg::ST_SRCH;
					end
				end
				fce_pkg::ST_LINK: begin
					state_q <= fce_pkg::ST_HOP;
				end
				fce_pkg::ST_FREE_RD: begin
					state_q <= fce_pkg::ST_FREE_EV;
				end
				fce_pkg::ST_FREE_EV: begin
					if ({1'b0, b_q} < lo_q)
						lo_q <= {1'b0, b_q};
					if (nx_end || nx_bad || (mem_rdata == b_q) || i_last)
						state_q <= fce_pkg::ST_DONE;
					else
						state_q <= fce_pkg::ST_FREE_RD;
				end
				fce_pkg::ST_DONE: begin
					if (res_can_load)
						state_q <= fce_pkg::ST_IDLE;
				end
				default: begin
					state_q <= fce_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			fce_pkg::ST_IDLE: begin
				if (acc) begin
					ext_q        <= extend;
					hops_q       <= hop_count;
					b_q          <= has_chain ? start_block : '0;
					first_q      <= has_chain ? start_block : '0;
					cnt_q        <= '0;
					i_q          <= '0;
					s_q          <= lo_q;
					pend_first_q <= 1'b1;
					if ((kind == fce_pkg::KIND_WALK) && empty_in && !extend)
						st_q <= fce_pkg::STAT_PAST_END;
					else
						st_q <= fce_pkg::STAT_OK;
				end
			end
			fce_pkg::ST_HOP_EV: begin
				if (nx_end) begin
					if (!ext_q)
						st_q <= fce_pkg::STAT_PAST_END;
					s_q          <= lo_q;
					pend_first_q <= 1'b0;
				end else if (nx_bad) begin
					st_q <= fce_pkg::STAT_BROKEN;
				end else begin
					b_q    <= mem_rdata;
					hops_q <= hops_q - fce_pkg::ADDR_W'(1);
				end
			end
			fce_pkg::ST_SRCH: begin
				if (s_out)
					st_q <= fce_pkg::STAT_NO_FREE;
			end
			fce_pkg::ST_SRCH_EV: begin
				if (s_free) begin
					if (pend_first_q) begin
						b_q     <= s_q[fce_pkg::ADDR_W-1:0];
						first_q <= s_q[fce_pkg::ADDR_W-1:0];
						cnt_q   <= fce_pkg::NB_W'(1);
					end
				end else begin
					s_q <= s_q + fce_pkg::NB_W'(1);
				end
			end
			fce_pkg::ST_LINK: begin
				b_q    <= s_q[fce_pkg::ADDR_W-1:0];
				cnt_q  <= cnt_q + fce_pkg::NB_W'(1);
				hops_q <= hops_q - fce_pkg::ADDR_W'(1);
			end
			fce_pkg::ST_FREE_EV: begin
				if (nx_end) begin
					st_q <= fce_pkg::STAT_OK;
				end else if (nx_bad || (mem_rdata == b_q)) begin
					st_q <= fce_pkg::STAT_BROKEN;
				end else begin
					b_q <= mem_rdata;
					i_q <= i_q + fce_pkg::NB_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/fat_chain_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_engine
// File allocation table chain manager: format, walk/extend and free of
// block chains held in a 1024-entry link table memory.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | kind, has_start, start_block, hop_count, extend
//  out     | out_valid / out_ready | status, block, first_block, new_blocks
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request at a time. Walk: each hop reads a link entry and then
//  evaluates it; free: each released block is read and then marked free;
//  each allocation scans from a kept low-water mark, one entry read at a
//  time, and then links the new block. Format sweeps the whole table.
//  After reset a clearing pass over the table runs with in_ready low;
//  cfg is always ready. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module fat_chain_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       kind,
	input  logic                             has_start,
	input  logic [fce_pkg::ADDR_W-1:0]       start_block,
	input  logic [fce_pkg::ADDR_W-1:0]       hop_count,
	input  logic                             extend,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [fce_pkg::ADDR_W-1:0]       block,
	output logic [fce_pkg::ADDR_W-1:0]       first_block,
	output logic [fce_pkg::NB_W-1:0]         new_blocks,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fce_pkg::NB_W-1:0]         cfg_data
);

	logic [fce_pkg::NB_W-1:0]   n_q;
	logic [fce_pkg::FB_W-1:0]   fb_q;
	fce_pkg::mem_req_t          mem_req;
	logic [fce_pkg::LINK_W-1:0] mem_rdata;
	logic                       res_load;
	logic                       res_can_load;
	fce_pkg::res_t              res;
	fce_pkg::res_t              out_data;

	assign cfg_ready = 1'b1;

	// registers keep the saturated values in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= fce_pkg::NB_W'(fce_pkg::MAX_BLOCKS);
			fb_q <= fce_pkg::FB_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fce_pkg::REG_NUM_BLOCKS: n_q  <= fce_pkg::sat_blocks(cfg_data);
				fce_pkg::REG_FAT_BLOCKS: fb_q <= fce_pkg::sat_fat(cfg_data[fce_pkg::FB_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	fce_ram #(
		.WIDTH (fce_pkg::LINK_W),
		.DEPTH (fce_pkg::MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	fce_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_q          (n_q),
		.fb_q         (fb_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.has_start    (has_start),
		.start_block  (start_block),
		.hop_count    (hop_count),
		.extend       (extend),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.res_load     (res_load),
		.res          (res),
		.res_can_load (res_can_load)
	);

	fce_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.can_load  (res_can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (out_data)
	);

	assign status      = out_data.status;
	assign block       = out_data.block;
	assign first_block = out_data.first_block;
	assign new_blocks  = out_data.new_blocks;

endmodule

// ===== rtl/fce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_checker
// Port-level checks of the chain engine, bound to the top level.
// ----------------------------------------------------------------------------
module fce_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 status,
	input logic [fce_pkg::ADDR_W-1:0] block,
	input logic [fce_pkg::ADDR_W-1:0] first_block,
	input logic [fce_pkg::NB_W-1:0]   new_blocks
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block) &&
			$stable(first_block) && $stable(new_blocks))
		else $error("result changed while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// a new result only comes out of a request in progress
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_blocks <= fce_pkg::NB_W'(fce_pkg::MAX_BLOCKS))
		else $error("allocation count out of range");

endmodule

bind fat_chain_engine fce_checker u_fce_checker (.*);
